/* sv/chbd_pkg.sv */
// Package for the chunked body decoder: shared types and constants.
// Used by the front, queue, back and checker modules; depends on nothing.
package chbd_pkg;

    // Result kinds on the output channel
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_EXCESS   = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    // Characters of interest
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Radix of a size digit, in bits
    localparam int DIGIT_BITS = 4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Decoder phase
    typedef enum logic [3:0] {
        PH_LEAD    = 4'd0,
        PH_DIGITS  = 4'd1,
        PH_IGNORE  = 4'd2,
        PH_DATA    = 4'd3,
        PH_DATA_CR = 4'd4,
        PH_DATA_LF = 4'd5,
        PH_END_CR  = 4'd6,
        PH_END_LF  = 4'd7,
        PH_DONE    = 4'd8,
        PH_ERROR   = 4'd9
    } phase_t;

    // Classified body byte, passed from front to back
    typedef struct packed {
        logic [7:0]            data;
        logic                  new_body;
        logic                  is_cr;
        logic                  is_lf;
        logic                  is_space;
        logic                  is_hex;
        logic [DIGIT_BITS-1:0] digit;
    } cls_word_t;

endpackage

/* sv/http_chunked_body_decoder.sv */
// HTTP/1.1 chunked body decoder. Takes one body byte per cycle unless stalled
// and gives at most one result word per byte: a payload byte, an end-of-body
// marker, an excess byte after the end, or a size overflow error. Sustained
// rate is one byte per cycle while the output is not stalled; the back part's
// per-word state update sets it. A taken byte is written into the queue and
// then loaded into the output register. A four-word queue between the
// classifier and the parser lets the input keep flowing, until it fills, while
// the output is stalled. Raise new_body on the first byte of a body to restart
// the parser. SIZE_BITS sets the largest chunk size accepted (16 to 64).
// Depends on chbd_pkg, chbd_front, chbd_queue and chbd_back.
module http_chunked_body_decoder
#(
    parameter int SIZE_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       new_body,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] kind
);

    chbd_pkg::cls_word_t wr_word;
    chbd_pkg::cls_word_t rd_word;
    logic                push;
    logic                full;
    logic                pop;
    logic                not_empty;

    // Classify incoming bytes
    chbd_front u_front
    (
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .new_body (new_body),
        .full     (full),
        .in_stall (in_stall),
        .push     (push),
        .word     (wr_word)
    );

    // Decouple front and back
    chbd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_word   (wr_word),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_word   (rd_word)
    );

    // Parse and emit results
    chbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (not_empty),
        .word       (rd_word),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .kind       (kind)
    );

endmodule

/* sv/chbd_front.sv */
// Front part of the chunked body decoder: classifies each incoming byte.
// Depends on chbd_pkg; feeds chbd_queue.
module chbd_front
(
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               new_body,
    input  logic               full,
    output logic               in_stall,
    output logic               push,
    output chbd_pkg::cls_word_t word
);

    logic       dec_digit;
    logic       low_hex;
    logic       up_hex;

    // Recognise hex digits in both cases
    assign dec_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    assign low_hex   = (in_byte >= 8'h61) && (in_byte <= 8'h66);
    assign up_hex    = (in_byte >= 8'h41) && (in_byte <= 8'h46);

    // Build the classified word
    always_comb
    begin
        word.data     = in_byte;
        word.new_body = new_body;
        word.is_cr    = (in_byte == chbd_pkg::CHAR_CR);
        word.is_lf    = (in_byte == chbd_pkg::CHAR_LF);
        word.is_space = (in_byte == 8'h20) || (in_byte == 8'h09) || (in_byte == 8'h0A)
                     || (in_byte == 8'h0B) || (in_byte == 8'h0C) || (in_byte == 8'h0D);
        word.is_hex   = dec_digit || low_hex || up_hex;
        if (dec_digit)
        begin
            word.digit = in_byte[3:0];
        end
        else if (low_hex || up_hex)
        begin
            // a..f and A..F share their low three bits: 1..6 maps to 10..15
            word.digit = chbd_pkg::DIGIT_BITS'(in_byte[2:0] + 3'd1) + 4'd8;
        end
        else
        begin
            word.digit = '0;
        end
    end

    // Take a byte whenever the queue has room
    assign in_stall = full;
    assign push     = in_valid && !full;

endmodule

/* sv/chbd_queue.sv */
// Short queue of classified words between the front and back parts.
// Depends on chbd_pkg.
module chbd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  chbd_pkg::cls_word_t wr_word,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output chbd_pkg::cls_word_t rd_word
);

    chbd_pkg::cls_word_t            entry_reg [chbd_pkg::QUEUE_DEPTH];
    logic [chbd_pkg::QPTR_BITS:0]   wr_ptr_reg;
    logic [chbd_pkg::QPTR_BITS:0]   wr_ptr_next;
    logic [chbd_pkg::QPTR_BITS:0]   rd_ptr_reg;
    logic [chbd_pkg::QPTR_BITS:0]   rd_ptr_next;

    // Derive full and empty from the wrap bit
    assign not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign full      = (wr_ptr_reg[chbd_pkg::QPTR_BITS] != rd_ptr_reg[chbd_pkg::QPTR_BITS])
                    && (wr_ptr_reg[chbd_pkg::QPTR_BITS-1:0]
                        == rd_ptr_reg[chbd_pkg::QPTR_BITS-1:0]);
    assign rd_word   = entry_reg[rd_ptr_reg[chbd_pkg::QPTR_BITS-1:0]];

    // Advance pointers
    assign wr_ptr_next = wr_ptr_reg + (chbd_pkg::QPTR_BITS+1)'(push);
    assign rd_ptr_next = rd_ptr_reg + (chbd_pkg::QPTR_BITS+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg[chbd_pkg::QPTR_BITS-1:0]] <= wr_word;
        end
    end

endmodule

/* sv/chbd_back.sv */
// Back part of the chunked body decoder: size line parser, data counter
// and output register. Depends on chbd_pkg; takes words from chbd_queue.
module chbd_back
#(
    parameter int SIZE_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                word_valid,
    input  chbd_pkg::cls_word_t word,
    output logic                pop,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic [1:0]          kind
);

    chbd_pkg::phase_t       phase_reg;
    chbd_pkg::phase_t       phase_next;
    logic [SIZE_BITS-1:0]   acc_reg;
    logic [SIZE_BITS-1:0]   acc_next;
    logic [SIZE_BITS-1:0]   left_reg;
    logic [SIZE_BITS-1:0]   left_next;
    logic                   cr_reg;
    logic                   cr_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_byte_reg;
    logic [7:0]             out_byte_next;
    logic [1:0]             kind_reg;
    logic [1:0]             kind_next;

    chbd_pkg::phase_t       cur_phase;
    logic [SIZE_BITS-1:0]   cur_acc;
    logic [SIZE_BITS-1:0]   cur_left;
    logic                   cur_cr;
    logic                   in_line;
    logic                   line_mode;
    chbd_pkg::phase_t       line_phase;
    logic                   line_cr;
    logic                   cr_lf;
    chbd_pkg::phase_t       p2;
    logic                   step_digit;
    logic                   top_nz;
    logic                   acc_zero;
    logic                   end_hit;
    logic                   ovf_hit;
    logic [SIZE_BITS-1:0]   left_dec;
    logic                   emit;
    logic [1:0]             emit_kind;
    logic [7:0]             emit_byte;

    // Take a word when the output register is free or being drained
    assign pop = word_valid && (!out_valid_reg || !out_stall);

    // Apply the new body restart before anything else
    assign cur_phase = word.new_body ? chbd_pkg::PH_LEAD : phase_reg;
    assign cur_acc   = word.new_body ? '0 : acc_reg;
    assign cur_left  = word.new_body ? '0 : left_reg;
    assign cur_cr    = word.new_body ? 1'b0 : cr_reg;

    // A byte missing the CR LF after data is parsed as the start of a size line
    assign in_line   = (cur_phase == chbd_pkg::PH_LEAD) || (cur_phase == chbd_pkg::PH_DIGITS)
                    || (cur_phase == chbd_pkg::PH_IGNORE);
    assign line_mode = in_line
                    || ((cur_phase == chbd_pkg::PH_DATA_CR) && !word.is_cr)
                    || ((cur_phase == chbd_pkg::PH_DATA_LF) && !word.is_lf);
    assign line_phase = in_line ? cur_phase : chbd_pkg::PH_LEAD;
    assign line_cr    = in_line && cur_cr;

    // Size line decisions
    assign cr_lf    = line_cr && word.is_lf;
    assign p2       = (line_cr && (line_phase == chbd_pkg::PH_DIGITS)) ? chbd_pkg::PH_IGNORE
                                                                        : line_phase;
    assign acc_zero = (cur_acc == '0);
    assign top_nz   = (cur_acc[SIZE_BITS-1 -: chbd_pkg::DIGIT_BITS] != '0);
    assign step_digit = line_mode && !cr_lf && !word.is_cr && (p2 != chbd_pkg::PH_IGNORE)
                     && !((p2 == chbd_pkg::PH_LEAD) && word.is_space) && word.is_hex;
    assign end_hit  = line_mode && cr_lf && acc_zero;
    assign ovf_hit  = step_digit && top_nz;

    // Count down the chunk payload
    assign left_dec = cur_left - SIZE_BITS'(cur_left != '0);

    // Next state
    always_comb
    begin
        phase_next = cur_phase;
        acc_next   = cur_acc;
        left_next  = cur_left;
        cr_next    = 1'b0;
        if (line_mode)
        begin
            if (cr_lf)
            begin
                if (acc_zero)
                begin
                    phase_next = chbd_pkg::PH_END_CR;
                end
                else
                begin
                    left_next  = cur_acc;
                    acc_next   = '0;
                    phase_next = chbd_pkg::PH_DATA;
                end
            end
            else if (word.is_cr)
            begin
                phase_next = p2;
                cr_next    = 1'b1;
            end
            else if (p2 == chbd_pkg::PH_IGNORE)
            begin
                phase_next = p2;
            end
            else if ((p2 == chbd_pkg::PH_LEAD) && word.is_space)
            begin
                phase_next = p2;
            end
            else if (!word.is_hex)
            begin
                phase_next = chbd_pkg::PH_IGNORE;
            end
            else if (top_nz)
            begin
                phase_next = chbd_pkg::PH_ERROR;
            end
            else
            begin
                acc_next   = {cur_acc[SIZE_BITS-chbd_pkg::DIGIT_BITS-1:0], word.digit};
                phase_next = chbd_pkg::PH_DIGITS;
            end
        end
        else
        begin
            case (cur_phase)
                chbd_pkg::PH_DATA:
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = chbd_pkg::PH_DATA_CR;
                    end
                end
                chbd_pkg::PH_DATA_CR:
                begin
                    phase_next = chbd_pkg::PH_DATA_LF;
                end
                chbd_pkg::PH_DATA_LF:
                begin
                    phase_next = chbd_pkg::PH_LEAD;
                end
                chbd_pkg::PH_END_CR:
                begin
                    phase_next = word.is_cr ? chbd_pkg::PH_END_LF : chbd_pkg::PH_DONE;
                end
                chbd_pkg::PH_END_LF:
                begin
                    phase_next = chbd_pkg::PH_DONE;
                end
                chbd_pkg::PH_DONE:
                begin
                    phase_next = chbd_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = chbd_pkg::PH_ERROR;
                end
            endcase
        end
    end

    // Result for this word
    always_comb
    begin
        emit      = 1'b0;
        emit_kind = chbd_pkg::KIND_PAYLOAD;
        emit_byte = '0;
        if (end_hit)
        begin
            emit      = 1'b1;
            emit_kind = chbd_pkg::KIND_END;
        end
        else if (ovf_hit)
        begin
            emit      = 1'b1;
            emit_kind = chbd_pkg::KIND_OVERFLOW;
        end
        else if (!line_mode)
        begin
            case (cur_phase)
                chbd_pkg::PH_DATA:
                begin
                    emit      = 1'b1;
                    emit_kind = chbd_pkg::KIND_PAYLOAD;
                    emit_byte = word.data;
                end
                chbd_pkg::PH_END_CR:
                begin
                    emit      = !word.is_cr;
                    emit_kind = chbd_pkg::KIND_EXCESS;
                    emit_byte = word.data;
                end
                chbd_pkg::PH_END_LF:
                begin
                    emit      = !word.is_lf;
                    emit_kind = chbd_pkg::KIND_EXCESS;
                    emit_byte = word.data;
                end
                chbd_pkg::PH_DONE:
                begin
                    emit      = 1'b1;
                    emit_kind = chbd_pkg::KIND_EXCESS;
                    emit_byte = word.data;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        kind_next      = kind_reg;
        if (!out_valid_reg || !out_stall)
        begin
            out_valid_next = pop && emit;
            if (pop && emit)
            begin
                out_byte_next = emit_byte;
                kind_next     = emit_kind;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= chbd_pkg::PH_LEAD;
            acc_reg       <= '0;
            left_reg      <= '0;
            cr_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                left_reg  <= left_next;
                cr_reg    <= cr_next;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        kind_reg     <= kind_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign kind      = kind_reg;

endmodule

/* sv/chbd_checker.sv */
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on chbd_pkg and http_chunked_body_decoder.
module chbd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic [1:0] kind
);

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind))
    else $error("stalled result word changed");

    // End and overflow words carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == chbd_pkg::KIND_END || kind == chbd_pkg::KIND_OVERFLOW)
        |-> out_byte == 8'h00)
    else $error("end or overflow word with non-zero byte");

    // Leave reset empty and ready
    assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid && !in_stall)
    else $error("not empty and ready after reset");

    // The queue cannot fill on the first cycle of a burst
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(in_stall) && !$past(in_valid) && $past(rst_n) |-> !in_stall)
    else $error("input stalled without a word taken");

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .kind      (kind)
);

/* tb/http_chunked_body_decoder_test.sv */
// Self-checking testbench for http_chunked_body_decoder: feeds chunked bodies
// byte by byte, predicts every result word and checks each one at the output.
// Depends on chbd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module http_chunked_body_decoder_test;

    localparam int SIZE_BITS    = 32;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_WORDS  = 456;
    localparam int MAX_REPORTS  = 100;

    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_VT   = 8'h0B;
    localparam logic [7:0] CHAR_FF   = 8'h0C;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } dec_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       new_body;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic [1:0] kind;

    // Decoder state as the predictor sees it
    chbd_pkg::phase_t     dec_phase;
    logic [SIZE_BITS-1:0] size_acc;
    logic [SIZE_BITS-1:0] left_cnt;
    bit                   cr_pending;

    dec_result_t pending_results[$];
    int          gap_pct;
    int          stall_pct;
    bit          body_start;
    int          words_sent;
    int          fail_count;
    int          cycles;
    int          kind_seen[4];

    http_chunked_body_decoder #(
        .SIZE_BITS (SIZE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .new_body  (new_body),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .kind      (kind)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Handle one byte of a size line; results here carry a zero byte
    function automatic void size_line_byte(input logic [7:0] b, output bit got,
                                           output dec_result_t r);
        logic [3:0] dig;
        bit         is_hex;
        got = 1'b0;
        r   = '{8'h00, chbd_pkg::KIND_END};
        if (cr_pending)
        begin
            cr_pending = 1'b0;
            if (b == chbd_pkg::CHAR_LF)
            begin
                if (size_acc == '0)
                begin
                    dec_phase = chbd_pkg::PH_END_CR;
                    got = 1'b1;
                    return;
                end
                left_cnt  = size_acc;
                size_acc  = '0;
                dec_phase = chbd_pkg::PH_DATA;
                return;
            end
            if (dec_phase == chbd_pkg::PH_DIGITS)
                dec_phase = chbd_pkg::PH_IGNORE;
        end
        if (b == chbd_pkg::CHAR_CR)
        begin
            cr_pending = 1'b1;
            return;
        end
        if (dec_phase == chbd_pkg::PH_IGNORE)
            return;
        if (dec_phase == chbd_pkg::PH_LEAD
            && (b == CHAR_SP || b == CHAR_TAB || b == chbd_pkg::CHAR_LF
                || b == CHAR_VT || b == CHAR_FF))
            return;
        is_hex = 1'b1;
        dig    = '0;
        if (b >= "0" && b <= "9")
            dig = 4'(b - "0");
        else if (b >= "a" && b <= "f")
            dig = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F")
            dig = 4'(b - "A" + 8'd10);
        else
            is_hex = 1'b0;
        if (!is_hex)
        begin
            dec_phase = chbd_pkg::PH_IGNORE;
            return;
        end
        // One more digit would not fit in SIZE_BITS
        if (size_acc[SIZE_BITS-1 -: chbd_pkg::DIGIT_BITS] != '0)
        begin
            dec_phase = chbd_pkg::PH_ERROR;
            got = 1'b1;
            r   = '{8'h00, chbd_pkg::KIND_OVERFLOW};
            return;
        end
        size_acc  = {size_acc[SIZE_BITS-chbd_pkg::DIGIT_BITS-1:0], dig};
        dec_phase = chbd_pkg::PH_DIGITS;
    endfunction

    // Advance the predicted state by one accepted word
    function automatic void predict_word(input logic [7:0] b, input logic nb,
                                         output bit got, output dec_result_t r);
        got = 1'b0;
        r   = '{8'h00, chbd_pkg::KIND_PAYLOAD};
        if (nb)
        begin
            dec_phase  = chbd_pkg::PH_LEAD;
            size_acc   = '0;
            left_cnt   = '0;
            cr_pending = 1'b0;
        end
        case (dec_phase)
            chbd_pkg::PH_LEAD, chbd_pkg::PH_DIGITS, chbd_pkg::PH_IGNORE:
                size_line_byte(b, got, r);
            chbd_pkg::PH_DATA:
            begin
                if (left_cnt != '0)
                    left_cnt = left_cnt - SIZE_BITS'(1);
                if (left_cnt == '0)
                    dec_phase = chbd_pkg::PH_DATA_CR;
                got = 1'b1;
                r   = '{b, chbd_pkg::KIND_PAYLOAD};
            end
            chbd_pkg::PH_DATA_CR:
            begin
                if (b == chbd_pkg::CHAR_CR)
                    dec_phase = chbd_pkg::PH_DATA_LF;
                else
                begin
                    // No CR LF after the data: the byte opens the next size line
                    dec_phase = chbd_pkg::PH_LEAD;
                    size_line_byte(b, got, r);
                end
            end
            chbd_pkg::PH_DATA_LF:
            begin
                dec_phase = chbd_pkg::PH_LEAD;
                if (b != chbd_pkg::CHAR_LF)
                    size_line_byte(b, got, r);
            end
            chbd_pkg::PH_END_CR:
            begin
                if (b == chbd_pkg::CHAR_CR)
                    dec_phase = chbd_pkg::PH_END_LF;
                else
                begin
                    dec_phase = chbd_pkg::PH_DONE;
                    got = 1'b1;
                    r   = '{b, chbd_pkg::KIND_EXCESS};
                end
            end
            chbd_pkg::PH_END_LF:
            begin
                dec_phase = chbd_pkg::PH_DONE;
                if (b != chbd_pkg::CHAR_LF)
                begin
                    got = 1'b1;
                    r   = '{b, chbd_pkg::KIND_EXCESS};
                end
            end
            chbd_pkg::PH_DONE:
            begin
                got = 1'b1;
                r   = '{b, chbd_pkg::KIND_EXCESS};
            end
            default:
                dec_phase = chbd_pkg::PH_ERROR;
        endcase
    endfunction

    // Offer one word, wait for it to be taken and log its expected result
    task automatic send_word(input logic [7:0] b);
        logic        nb;
        bit          got;
        dec_result_t r;
        nb = body_start;
        body_start = 1'b0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        new_body <= nb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(b, nb, got, r);
        if (got)
            pending_results.push_back(r);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input int unsigned v);
        if (v < 10)
            return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    function automatic logic [7:0] non_cr_byte();
        logic [7:0] x;
        do
            x = 8'($urandom_range(0, 255));
        while (x == chbd_pkg::CHAR_CR);
        return x;
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 4))
            0: return CHAR_SP;
            1: return CHAR_TAB;
            2: return CHAR_VT;
            3: return CHAR_FF;
            default: return chbd_pkg::CHAR_LF;
        endcase
    endfunction

    task automatic send_crlf();
        send_word(chbd_pkg::CHAR_CR);
        send_word(chbd_pkg::CHAR_LF);
    endtask

    // Hex size with optional leading zeros and mixed letter case
    task automatic send_size(input int unsigned n, input int zeros);
        int nd;
        nd = 1;
        while ((n >> (4 * nd)) != 0)
            nd++;
        repeat (zeros) send_word("0");
        for (int i = nd - 1; i >= 0; i--)
            send_word(hex_char((n >> (4 * i)) & 15));
    endtask

    // Junk after the digits; rough lines may use a lone CR instead of ';'
    task automatic send_extension(input bit rough);
        if (rough && $urandom_range(0, 1))
        begin
            send_word(chbd_pkg::CHAR_CR);
            send_word(CHAR_SP);
        end
        else
            send_word(CHAR_SEMI);
        repeat ($urandom_range(0, 4)) send_word(non_cr_byte());
    endtask

    // One body: a few chunks, the last chunk line, then an optional trailer
    task automatic send_body(input bit rough);
        int unsigned n;
        body_start = 1'b1;
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 5) == 0)
                send_word(pick_space());
            if (rough && $urandom_range(0, 3) == 0)
            begin
                send_word(chbd_pkg::CHAR_CR);
                send_word(CHAR_SP);
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
            send_size(n, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            if ($urandom_range(0, 3) == 0)
                send_extension(rough);
            send_crlf();
            repeat (n) send_word(8'($urandom_range(0, 255)));
            // Rough bodies may drop the CR LF after the data, or just the LF
            if (!rough || $urandom_range(0, 2) != 0)
                send_crlf();
            else if ($urandom_range(0, 1))
                send_word(chbd_pkg::CHAR_CR);
        end
        // Last chunk: a zero size or an empty size line
        if ($urandom_range(0, 4) == 0)
        begin
            if ($urandom_range(0, 1))
                send_word(pick_space());
        end
        else
            send_size(0, $urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0)
            send_extension(rough);
        send_crlf();
        case ($urandom_range(0, 3))
            0: ;
            1: send_crlf();
            2:
            begin
                send_crlf();
                repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    send_word(chbd_pkg::CHAR_CR);
                repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Size line that runs past SIZE_BITS, or just reaches it
    task automatic send_oversize();
        body_start = 1'b1;
        send_word(hex_char($urandom_range(1, 15)));
        repeat ($urandom_range(7, 10)) send_word(hex_char($urandom_range(0, 15)));
        repeat ($urandom_range(0, 3)) send_word(8'($urandom_range(0, 255)));
    endtask

    // Random bytes, with restarts scattered among them
    task automatic send_noise();
        repeat ($urandom_range(1, 12))
        begin
            body_start = ($urandom_range(0, 3) == 0);
            send_word(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_bodies(input int goal);
        int stop_at;
        int pick;
        stop_at = words_sent + goal;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                send_body(1'b0);
            else if (pick < 82)
                send_body(1'b1);
            else if (pick < 90)
                send_oversize();
            else
                send_noise();
        end
    endtask

    task automatic test_directed();
        gap_pct   = 0;
        stall_pct = 0;
        body_start = 1'b1;
        send_word(CHAR_SP);
        send_word(chbd_pkg::CHAR_CR);   // lone CR before the digits: whitespace
        send_word("1");
        send_word(chbd_pkg::CHAR_CR);   // lone CR after a digit: rest of the line ignored
        send_word("z");
        send_crlf();
        send_word(8'hFF);       // single payload byte, no CR LF after it
        send_word("0");
        send_crlf();            // end of body
        send_word(chbd_pkg::CHAR_CR);   // CR then a non-LF byte: that byte and all after it are excess
        send_word(8'h00);
        send_word(8'hFF);
        // Ninth significant digit overflows, the byte after it is dropped
        body_start = 1'b1;
        send_word("f");
        repeat (7) send_word("F");
        send_word("a");
        send_word("A");
    endtask

    task automatic test_steady();
        gap_pct   = 0;
        stall_pct = 0;
        run_bodies(PHASE_WORDS);
    endtask

    task automatic test_sender_gaps();
        gap_pct   = 80;
        stall_pct = 0;
        run_bodies(PHASE_WORDS);
    endtask

    task automatic test_receiver_stalls();
        gap_pct   = 0;
        stall_pct = 80;
        run_bodies(PHASE_WORDS);
    endtask

    task automatic test_both_gaps();
        gap_pct   = 34;
        stall_pct = 34;
        run_bodies(PHASE_WORDS);
    endtask

    // Drive the receiver stall
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        dec_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("unexpected word: out_byte %02h kind %0d", out_byte, kind);
            end
            else
            begin
                want = pending_results.pop_front();
                kind_seen[want.kind]++;
                if (out_byte !== want.data)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                end
                if (kind !== want.kind)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $error("timed out with %0d results outstanding", pending_results.size());
            $display("http_chunked_body_decoder_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = 8'h00;
        new_body   = 1'b0;
        out_stall  = 1'b0;
        gap_pct    = 0;
        stall_pct  = 0;
        body_start = 1'b0;
        dec_phase  = chbd_pkg::PH_LEAD;
        size_acc   = '0;
        left_cnt   = '0;
        cr_pending = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_steady();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_gaps();

        // Drop valid and let the last results drain
        in_valid <= 1'b0;
        stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Fed %0d body bytes through five idling phases, clean and damaged bodies.",
                 words_sent);
        $display("Results checked: %0d payload, %0d end, %0d excess, %0d overflow.",
                 kind_seen[chbd_pkg::KIND_PAYLOAD], kind_seen[chbd_pkg::KIND_END],
                 kind_seen[chbd_pkg::KIND_EXCESS], kind_seen[chbd_pkg::KIND_OVERFLOW]);
        if (fail_count == 0)
            $display("http_chunked_body_decoder_test: done, clean");
        else
            $display("http_chunked_body_decoder_test: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
sv/chbd_pkg.sv
sv/chbd_front.sv
sv/chbd_queue.sv
sv/chbd_back.sv
sv/http_chunked_body_decoder.sv
sv/chbd_checker.sv
tb/http_chunked_body_decoder_test.sv
